// File: hdl/rotation_matrix_to_quaternion_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the rotation matrix to quaternion checker.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH

// Plain property, clocked on clk_i and switched off while reset is low.
`define RMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Overlapping implication, same clock and reset.
`define RMQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/rmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants and the branch code of the matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int NUM_PARTS      = 3;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_Y     = 2'd1,
    BR_Z     = 2'd2,
    BR_X     = 2'd3
  } branch_e;

endpackage

// File: hdl/rotation_matrix_to_quaternion_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion
// Converts one signed fixed point 3x3 rotation matrix per word into a unit
// quaternion with the four-case method and reports the case taken.
// ----------------------------------------------------------------------------
// The pipeline takes one matrix word in every cycle unless it is held. Each
// result passes through one input stage, DATA_WIDTH square root stages
// producing one root bit each, one divider setup stage, DATA_WIDTH
// shared-divisor quotient stages, one saturation stage and the output
// register. The whole pipeline advances together; it holds only while a
// result sits in the output register and out_ready_i is low, so in_ready_o
// is low exactly while it holds.
module rotation_matrix_to_quaternion_top #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] m11_i,
  input  logic signed [DATA_WIDTH-1:0] m12_i,
  input  logic signed [DATA_WIDTH-1:0] m13_i,
  input  logic signed [DATA_WIDTH-1:0] m21_i,
  input  logic signed [DATA_WIDTH-1:0] m22_i,
  input  logic signed [DATA_WIDTH-1:0] m23_i,
  input  logic signed [DATA_WIDTH-1:0] m31_i,
  input  logic signed [DATA_WIDTH-1:0] m32_i,
  input  logic signed [DATA_WIDTH-1:0] m33_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] quat_w_o,
  output logic signed [DATA_WIDTH-1:0] quat_x_o,
  output logic signed [DATA_WIDTH-1:0] quat_y_o,
  output logic signed [DATA_WIDTH-1:0] quat_z_o,
  output logic        [1:0]            branch_taken_o
);

  localparam int W     = DATA_WIDTH;
  localparam int NP    = rmq_pkg::NUM_PARTS;
  localparam int SQ_SB = 2 + NP * (W + 1);
  localparam int DV_SB = 2 + W;

  logic en;
  logic out_valid_q;

  logic                p_valid;
  rmq_pkg::branch_e    p_branch;
  logic        [W:0]   p_arg;
  logic signed [W:0]   p_num [NP];
  logic [SQ_SB-1:0]    p_sb;

  logic                sq_valid;
  logic [W-1:0]        sq_root;
  logic [SQ_SB-1:0]    sq_sb;
  logic signed [W:0]   sq_num [NP];
  logic [DV_SB-1:0]    sq_dsb;

  logic                dv_valid;
  logic signed [W-1:0] dv_quo [NP];
  logic [DV_SB-1:0]    dv_sb;
  rmq_pkg::branch_e    dv_branch;
  logic signed [W-1:0] dv_half;

  logic signed [W-1:0] w_d, x_d, y_d, z_d;
  logic signed [W-1:0] w_q, x_q, y_q, z_q;
  logic [1:0]          br_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  rmq_prep #(.DATA_WIDTH(W)) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .m11_i    (m11_i),
    .m12_i    (m12_i),
    .m13_i    (m13_i),
    .m21_i    (m21_i),
    .m22_i    (m22_i),
    .m23_i    (m23_i),
    .m31_i    (m31_i),
    .m32_i    (m32_i),
    .m33_i    (m33_i),
    .valid_o  (p_valid),
    .branch_o (p_branch),
    .arg_o    (p_arg),
    .num_o    (p_num)
  );

  assign p_sb = {p_num[2], p_num[1], p_num[0], p_branch};

  rmq_sqrt #(.DATA_WIDTH(W), .SB_W(SQ_SB)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_valid),
    .rad_i   (p_arg),
    .sb_i    (p_sb),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .sb_o    (sq_sb)
  );

  for (genvar l = 0; l < NP; l++) begin : g_unpack
    assign sq_num[l] = sq_sb[2 + l * (W + 1) +: W + 1];
  end

  // The branch part is the root halved, carried beside the quotients.
  assign sq_dsb = {W'(sq_root >> 1), sq_sb[1:0]};

  rmq_div #(.DATA_WIDTH(W), .LANES(NP), .SB_W(DV_SB)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .num_i   (sq_num),
    .root_i  (sq_root),
    .sb_i    (sq_dsb),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .sb_o    (dv_sb)
  );

  assign dv_branch = rmq_pkg::branch_e'(dv_sb[1:0]);
  assign dv_half   = dv_sb[DV_SB-1:2];

  always_comb begin
    case (dv_branch)
      rmq_pkg::BR_Y: begin
        w_d = dv_quo[0];
        x_d = dv_quo[1];
        y_d = dv_half;
        z_d = dv_quo[2];
      end
      rmq_pkg::BR_Z: begin
        w_d = dv_quo[0];
        x_d = dv_quo[1];
        y_d = dv_quo[2];
        z_d = dv_half;
      end
      rmq_pkg::BR_X: begin
        w_d = dv_quo[0];
        x_d = dv_half;
        y_d = dv_quo[1];
        z_d = dv_quo[2];
      end
      default: begin
        w_d = dv_half;
        x_d = dv_quo[0];
        y_d = dv_quo[1];
        z_d = dv_quo[2];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q  <= w_d;
      x_q  <= x_d;
      y_q  <= y_d;
      z_q  <= z_d;
      br_q <= dv_sb[1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign quat_w_o       = w_q;
  assign quat_x_o       = x_q;
  assign quat_y_o       = y_q;
  assign quat_z_o       = z_q;
  assign branch_taken_o = br_q;

endmodule

// File: hdl/rmq_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_prep
// Input stage: trace, branch choice, root argument and the three numerators.
// ----------------------------------------------------------------------------
module rmq_prep #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [DATA_WIDTH-1:0] m11_i,
  input  logic signed [DATA_WIDTH-1:0] m12_i,
  input  logic signed [DATA_WIDTH-1:0] m13_i,
  input  logic signed [DATA_WIDTH-1:0] m21_i,
  input  logic signed [DATA_WIDTH-1:0] m22_i,
  input  logic signed [DATA_WIDTH-1:0] m23_i,
  input  logic signed [DATA_WIDTH-1:0] m31_i,
  input  logic signed [DATA_WIDTH-1:0] m32_i,
  input  logic signed [DATA_WIDTH-1:0] m33_i,
  output logic                         valid_o,
  output rmq_pkg::branch_e             branch_o,
  output logic        [DATA_WIDTH:0]   arg_o,
  output logic signed [DATA_WIDTH:0]   num_o [rmq_pkg::NUM_PARTS]
);

  localparam int W = DATA_WIDTH;
  localparam int F = W - 2;
  localparam logic signed [W+1:0] ONE_FIX = (W+2)'(1) << F;

  logic signed [W+1:0] e11, e12, e13, e21, e22, e23, e31, e32, e33;
  logic signed [W+1:0] tr, arg_s;
  logic signed [W+1:0] n0, n1, n2;
  rmq_pkg::branch_e    branch_d, branch_q;
  logic        [W:0]   arg_d, arg_q;
  logic signed [W:0]   num_q [rmq_pkg::NUM_PARTS];
  logic                valid_q;

  assign e11 = (W+2)'(m11_i);
  assign e12 = (W+2)'(m12_i);
  assign e13 = (W+2)'(m13_i);
  assign e21 = (W+2)'(m21_i);
  assign e22 = (W+2)'(m22_i);
  assign e23 = (W+2)'(m23_i);
  assign e31 = (W+2)'(m31_i);
  assign e32 = (W+2)'(m32_i);
  assign e33 = (W+2)'(m33_i);
  assign tr  = e11 + e22 + e33;

  // The numerators are ordered as the three parts that are not the branch
  // part, taken in w, x, y, z order.
  always_comb begin
    if (tr > 0) begin
      branch_d = rmq_pkg::BR_TRACE;
      arg_s    = tr + ONE_FIX;
      n0       = e23 - e32;
      n1       = e31 - e13;
      n2       = e12 - e21;
    end else if (e22 > e11 && e22 > e33) begin
      branch_d = rmq_pkg::BR_Y;
      arg_s    = e22 - e11 - e33 + ONE_FIX;
      n0       = e31 - e13;
      n1       = e12 + e21;
      n2       = e23 + e32;
    end else if (e33 > e11) begin
      branch_d = rmq_pkg::BR_Z;
      arg_s    = e33 - e11 - e22 + ONE_FIX;
      n0       = e12 - e21;
      n1       = e31 + e13;
      n2       = e23 + e32;
    end else begin
      branch_d = rmq_pkg::BR_X;
      arg_s    = e11 - e22 - e33 + ONE_FIX;
      n0       = e23 - e32;
      n1       = e12 + e21;
      n2       = e31 + e13;
    end
    // A matrix that is not a rotation may give a negative argument.
    arg_d = arg_s[W+1] ? '0 : arg_s[W:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      branch_q <= branch_d;
      arg_q    <= arg_d;
      num_q[0] <= n0[W:0];
      num_q[1] <= n1[W:0];
      num_q[2] <= n2[W:0];
    end
  end

  assign valid_o  = valid_q;
  assign branch_o = branch_q;
  assign arg_o    = arg_q;
  assign num_o    = num_q;

endmodule

// File: hdl/rmq_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined digit-by-digit square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int SB_W       = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [DATA_WIDTH:0]   rad_i,
  input  logic [SB_W-1:0]       sb_i,
  output logic                  valid_o,
  output logic [DATA_WIDTH-1:0] root_o,
  output logic [SB_W-1:0]       sb_o
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = W - 2;
  localparam int AW = 2 * W;
  localparam int RW = W + 4;

  logic [AW-1:0]   rad_in [W];
  logic [RW-1:0]   rem_in [W];
  logic [W-1:0]    root_in [W];
  logic            v_in [W];
  logic [SB_W-1:0] sb_in [W];

  logic [AW-1:0]   rad_q [W];
  logic [RW-1:0]   rem_q [W];
  logic [W-1:0]    root_q [W];
  logic            v_q [W];
  logic [SB_W-1:0] sb_q [W];

  for (genvar j = 0; j < W; j++) begin : g_stage
    localparam int HI = AW - 1 - 2 * j;
    logic [RW-1:0] cur, trial, rem_d;
    logic [W-1:0]  root_d;

    if (j == 0) begin : g_first
      // The radicand is scaled by the fraction bits before the root is taken.
      assign rad_in[j]  = {1'b0, rad_i, {F{1'b0}}};
      assign rem_in[j]  = '0;
      assign root_in[j] = '0;
      assign v_in[j]    = valid_i;
      assign sb_in[j]   = sb_i;
    end else begin : g_next
      assign rad_in[j]  = rad_q[j-1];
      assign rem_in[j]  = rem_q[j-1];
      assign root_in[j] = root_q[j-1];
      assign v_in[j]    = v_q[j-1];
      assign sb_in[j]   = sb_q[j-1];
    end

    always_comb begin
      cur   = {rem_in[j][RW-3:0], rad_in[j][HI -: 2]};
      trial = RW'({root_in[j], 2'b01});
      if (cur >= trial) begin
        rem_d  = cur - trial;
        root_d = {root_in[j][W-2:0], 1'b1};
      end else begin
        rem_d  = cur;
        root_d = {root_in[j][W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[j]  <= rad_in[j];
        rem_q[j]  <= rem_d;
        root_q[j] <= root_d;
        sb_q[j]   <= sb_in[j];
      end
    end
  end

  assign valid_o = v_q[W-1];
  assign root_o  = root_q[W-1];
  assign sb_o    = sb_q[W-1];

endmodule

// File: hdl/rmq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider with several lanes that share one divisor.
// Each lane gives trunc(num * 2^(W-2) / (2 * root)), saturated.
// ----------------------------------------------------------------------------
module rmq_div #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int LANES      = rmq_pkg::NUM_PARTS,
  parameter int SB_W       = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [DATA_WIDTH:0]   num_i [LANES],
  input  logic        [DATA_WIDTH-1:0] root_i,
  input  logic        [SB_W-1:0]       sb_i,
  output logic                         valid_o,
  output logic signed [DATA_WIDTH-1:0] quo_o [LANES],
  output logic        [SB_W-1:0]       sb_o
);

  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] CAP = W'(1) << (W - 1);

  // Setup stage
  logic              s_v_q;
  logic [W:0]        s_den_q;
  logic              s_zero_q;
  logic [SB_W-1:0]   s_sb_q;
  logic [W+1:0]      s_r_q [LANES];
  logic [1:0]        s_low_q [LANES];
  logic              s_neg_q [LANES];
  logic              s_sat_q [LANES];

  // Quotient steps
  logic              v_in [W];
  logic [W:0]        den_in [W];
  logic              zero_in [W];
  logic [SB_W-1:0]   sb_in [W];
  logic [W+1:0]      r_in [W][LANES];
  logic [W-1:0]      q_in [W][LANES];
  logic [1:0]        low_in [W][LANES];
  logic              neg_in [W][LANES];
  logic              sat_in [W][LANES];

  logic              v_q [W];
  logic [W:0]        den_q [W];
  logic              zero_q [W];
  logic [SB_W-1:0]   sb_q [W];
  logic [W+1:0]      r_q [W][LANES];
  logic [W-1:0]      q_q [W][LANES];
  logic [1:0]        low_q [W][LANES];
  logic              neg_q [W][LANES];
  logic              sat_q [W][LANES];

  // Output stage
  logic              o_v_q;
  logic [SB_W-1:0]   o_sb_q;
  logic signed [W-1:0] o_quo_q [LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (en_i) begin
      s_v_q <= valid_i;
      o_v_q <= v_q[W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_den_q  <= {root_i, 1'b0};
      s_zero_q <= (root_i == '0);
      s_sb_q   <= sb_i;
      o_sb_q   <= sb_q[W-1];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_setup
    logic [W:0] mag;
    logic       neg;
    logic [W+2:0] den4;

    assign neg  = num_i[l][W];
    assign mag  = neg ? (W+1)'(0) - num_i[l] : num_i[l];
    assign den4 = {root_i, 3'b000};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_r_q[l]   <= (W+2)'(mag >> 2);
        s_low_q[l] <= mag[1:0];
        s_neg_q[l] <= neg;
        // A quotient of 2^W or more shows up as mag >= 4 * den.
        s_sat_q[l] <= ({2'b00, mag} >= den4);
      end
    end

    // Saturate, apply the sign and force zero for a zero root.
    logic [W-1:0]        qs;
    logic signed [W-1:0] res;
    always_comb begin
      qs = (sat_q[W-1][l] || q_q[W-1][l] > CAP) ? CAP : q_q[W-1][l];
      if (zero_q[W-1]) begin
        res = '0;
      end else if (neg_q[W-1][l]) begin
        res = W'(0) - qs;
      end else if (qs == CAP) begin
        res = CAP - W'(1);
      end else begin
        res = qs;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        o_quo_q[l] <= res;
      end
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_step
    if (k == 0) begin : g_first
      assign v_in[k]    = s_v_q;
      assign den_in[k]  = s_den_q;
      assign zero_in[k] = s_zero_q;
      assign sb_in[k]   = s_sb_q;
    end else begin : g_next
      assign v_in[k]    = v_q[k-1];
      assign den_in[k]  = den_q[k-1];
      assign zero_in[k] = zero_q[k-1];
      assign sb_in[k]   = sb_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_in[k];
        zero_q[k] <= zero_in[k];
        sb_q[k]   <= sb_in[k];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic         bit_in;
      logic [W+1:0] cur, r_d;
      logic [W-1:0] q_d;

      if (k == 0) begin : g_first
        assign r_in[k][l]   = s_r_q[l];
        assign q_in[k][l]   = '0;
        assign low_in[k][l] = s_low_q[l];
        assign neg_in[k][l] = s_neg_q[l];
        assign sat_in[k][l] = s_sat_q[l];
      end else begin : g_next
        assign r_in[k][l]   = r_q[k-1][l];
        assign q_in[k][l]   = q_q[k-1][l];
        assign low_in[k][l] = low_q[k-1][l];
        assign neg_in[k][l] = neg_q[k-1][l];
        assign sat_in[k][l] = sat_q[k-1][l];
      end

      // The scaled numerator has only its two lowest magnitude bits below
      // the starting remainder; every later bit is zero.
      if (k == 0) begin : g_b1
        assign bit_in = low_in[k][l][1];
      end else if (k == 1) begin : g_b0
        assign bit_in = low_in[k][l][0];
      end else begin : g_bz
        assign bit_in = 1'b0;
      end

      always_comb begin
        cur = {r_in[k][l][W:0], bit_in};
        if (cur >= {1'b0, den_in[k]}) begin
          r_d = cur - {1'b0, den_in[k]};
          q_d = {q_in[k][l][W-2:0], 1'b1};
        end else begin
          r_d = cur;
          q_d = {q_in[k][l][W-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[k][l]   <= r_d;
          q_q[k][l]   <= q_d;
          low_q[k][l] <= low_in[k][l];
          neg_q[k][l] <= neg_in[k][l];
          sat_q[k][l] <= sat_in[k][l];
        end
      end
    end
  end

  assign valid_o = o_v_q;
  assign quo_o   = o_quo_q;
  assign sb_o    = o_sb_q;

endmodule

// File: hdl/rmq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks of the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_top_defines.svh"

module rmq_checker #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic signed [DATA_WIDTH-1:0] m11_i,
  input logic signed [DATA_WIDTH-1:0] m12_i,
  input logic signed [DATA_WIDTH-1:0] m13_i,
  input logic signed [DATA_WIDTH-1:0] m21_i,
  input logic signed [DATA_WIDTH-1:0] m22_i,
  input logic signed [DATA_WIDTH-1:0] m23_i,
  input logic signed [DATA_WIDTH-1:0] m31_i,
  input logic signed [DATA_WIDTH-1:0] m32_i,
  input logic signed [DATA_WIDTH-1:0] m33_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic signed [DATA_WIDTH-1:0] quat_w_o,
  input logic signed [DATA_WIDTH-1:0] quat_x_o,
  input logic signed [DATA_WIDTH-1:0] quat_y_o,
  input logic signed [DATA_WIDTH-1:0] quat_z_o,
  input logic        [1:0]            branch_taken_o
);

  // A held result word stays valid, with its w part and branch code unchanged, until it is taken.
  `RMQ_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result word dropped")
  `RMQ_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(quat_w_o) && $stable(branch_taken_o), "held result word changed")

  // With a positive trace the root argument exceeds one, so w is positive.
  `RMQ_ASSERT_IMP(a_trace_w_pos, out_valid_o && (branch_taken_o == rmq_pkg::BR_TRACE), quat_w_o > 0, "w not positive on trace case")

  // The part picked by the diagonal is a halved root and never negative.
  `RMQ_ASSERT_IMP(a_y_nonneg, out_valid_o && (branch_taken_o == rmq_pkg::BR_Y), !quat_y_o[DATA_WIDTH-1], "y negative on y case")

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rmq_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion testbench
// Drives matrix words into the pipeline with random idling on both sides and
// checks every quaternion word against a fixed point predictor of the
// four-case conversion, including ties, clamped roots and saturation.
// ----------------------------------------------------------------------------

class quat_scoreboard;
  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    rmq_pkg::branch_e   br;
  } quat_t;

  quat_t pending_q[$];
  int    n_errors;
  int    n_checked;
  int    branch_seen[4];

  function automatic logic [63:0] isqrt_scaled(logic [63:0] a);
    logic [127:0] v;
    logic [127:0] rem;
    logic [127:0] root;
    logic [127:0] trial;
    v = {64'd0, a} << 30;
    rem = 0;
    root = 0;
    for (int p = 63; p >= 0; p--) begin
      rem = (rem << 2) | ((v >> (2 * p)) & 128'd3);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  function automatic logic signed [63:0] sat(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Quotient num / (2*s) in Q1.30, truncated toward zero and saturated.
  function automatic logic signed [31:0] scaled_part(logic signed [63:0] num,
                                                     logic [63:0] s);
    logic [127:0] mag;
    logic [127:0] q;
    logic signed [63:0] r;
    if (s == 0) return 32'sd0;
    mag = (num < 0) ? 128'(-num) : 128'(num);
    q = (mag << 30) / {63'd0, s, 1'b0};
    if (q > 128'h8000_0000) q = 128'h8000_0000;
    r = (num < 0) ? -64'(q) : 64'(q);
    return 32'(sat(r));
  endfunction

  function void note_matrix(logic signed [31:0] m[9]);
    logic signed [63:0] a[9];
    logic signed [63:0] tr;
    logic signed [63:0] arg;
    logic [63:0] s;
    quat_t e;
    for (int i = 0; i < 9; i++) a[i] = m[i];
    tr = a[0] + a[4] + a[8];
    if (tr > 0) begin
      e.br = rmq_pkg::BR_TRACE;
      s = isqrt_scaled(64'(tr + 64'sd1073741824));
      e.w = 32'(sat(64'(s >> 1)));
      e.x = scaled_part(a[5] - a[7], s);
      e.y = scaled_part(a[6] - a[2], s);
      e.z = scaled_part(a[1] - a[3], s);
    end else if (a[4] > a[0] && a[4] > a[8]) begin
      e.br = rmq_pkg::BR_Y;
      arg = a[4] - a[0] - a[8] + 64'sd1073741824;
      s = isqrt_scaled(arg < 0 ? 64'd0 : 64'(arg));
      e.y = 32'(sat(64'(s >> 1)));
      e.w = scaled_part(a[6] - a[2], s);
      e.x = scaled_part(a[1] + a[3], s);
      e.z = scaled_part(a[5] + a[7], s);
    end else if (a[8] > a[0]) begin
      e.br = rmq_pkg::BR_Z;
      arg = a[8] - a[0] - a[4] + 64'sd1073741824;
      s = isqrt_scaled(arg < 0 ? 64'd0 : 64'(arg));
      e.z = 32'(sat(64'(s >> 1)));
      e.w = scaled_part(a[1] - a[3], s);
      e.x = scaled_part(a[6] + a[2], s);
      e.y = scaled_part(a[5] + a[7], s);
    end else begin
      e.br = rmq_pkg::BR_X;
      arg = a[0] - a[4] - a[8] + 64'sd1073741824;
      s = isqrt_scaled(arg < 0 ? 64'd0 : 64'(arg));
      e.x = 32'(sat(64'(s >> 1)));
      e.w = scaled_part(a[5] - a[7], s);
      e.y = scaled_part(a[1] + a[3], s);
      e.z = scaled_part(a[6] + a[2], s);
    end
    pending_q.push_back(e);
  endfunction

  function void check_quat(quat_t got);
    quat_t e;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected word w=%0d x=%0d y=%0d z=%0d br=%0d", $time,
               got.w, got.x, got.y, got.z, got.br);
      n_errors++;
      return;
    end
    e = pending_q.pop_front();
    n_checked++;
    branch_seen[e.br]++;
    if (got.w !== e.w) begin
      $display("%0t: quat_w expected %0d actual %0d", $time, e.w, got.w);
      n_errors++;
    end
    if (got.x !== e.x) begin
      $display("%0t: quat_x expected %0d actual %0d", $time, e.x, got.x);
      n_errors++;
    end
    if (got.y !== e.y) begin
      $display("%0t: quat_y expected %0d actual %0d", $time, e.y, got.y);
      n_errors++;
    end
    if (got.z !== e.z) begin
      $display("%0t: quat_z expected %0d actual %0d", $time, e.z, got.z);
      n_errors++;
    end
    if (got.br !== e.br) begin
      $display("%0t: branch expected %0d actual %0d", $time, e.br, got.br);
      n_errors++;
    end
  endfunction
endclass

module testbench;
  localparam int LATENCY     = 68;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [31:0] ONE = 32'sh4000_0000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] mat[9];
  logic out_valid;
  logic out_ready;
  logic signed [31:0] q_w, q_x, q_y, q_z;
  logic [1:0] q_br;

  quat_scoreboard sb;
  int sender_idle;
  int receiver_idle;
  int cycles;

  rotation_matrix_to_quaternion_top i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .m11_i         (mat[0]),
    .m12_i         (mat[1]),
    .m13_i         (mat[2]),
    .m21_i         (mat[3]),
    .m22_i         (mat[4]),
    .m23_i         (mat[5]),
    .m31_i         (mat[6]),
    .m32_i         (mat[7]),
    .m33_i         (mat[8]),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .quat_w_o      (q_w),
    .quat_x_o      (q_x),
    .quat_y_o      (q_y),
    .quat_z_o      (q_z),
    .branch_taken_o(q_br)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: checked at the rising edge, ready redrawn at the falling one.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_quat({q_w, q_x, q_y, q_z, rmq_pkg::branch_e'(q_br)});
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_idle);
  end

  task automatic send_matrix(logic signed [31:0] m[9]);
    while ($urandom_range(99) < sender_idle) @(negedge clk);
    mat = m;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_matrix(m);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_diag(logic signed [31:0] d1, logic signed [31:0] d2,
                           logic signed [31:0] d3, logic signed [31:0] off);
    logic signed [31:0] m[9];
    m = '{d1, off, -off, off >>> 1, d2, off, -off, off >>> 2, d3};
    send_matrix(m);
  endtask

  // Random matrix: random entries, in some kinds with one diagonal entry near one or a tied diagonal.
  task automatic send_random;
    logic signed [31:0] m[9];
    int kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) begin
      if (kind == 0) m[i] = $urandom;
      else m[i] = $signed($urandom_range(32'h7fff_ffff)) - 32'sh4000_0000;
    end
    if (kind == 1) m[0] = ONE - $urandom_range(1 << 20);
    if (kind == 2) m[4] = ONE - $urandom_range(1 << 20);
    if (kind == 3) m[8] = ONE - $urandom_range(1 << 20);
    if (kind == 4) begin
      m[4] = m[0];
      m[8] = m[0];
    end
    send_matrix(m);
  endtask

  task automatic drain;
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    sb = new();
    cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    for (int i = 0; i < 9; i++) mat[i] = '0;
    sender_idle = 0;
    receiver_idle = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: identity, each branch, ties, clamped roots, extremes.
    send_diag(ONE, ONE, ONE, 0);
    send_diag(-ONE, ONE, -ONE, 32'sh0100_0000);
    send_diag(-ONE, -ONE, ONE, 32'sh0100_0000);
    send_diag(ONE, -ONE, -ONE, 32'sh0100_0000);
    send_diag(-ONE, -ONE, -ONE, 0);
    send_diag(0, 0, 0, 0);
    send_diag(-ONE, 0, 0, 32'sh1000_0000);
    send_diag(0, -ONE, 0, 32'sh1000_0000);
    send_diag(-32'sh2000_0000, -32'sh2000_0000, -32'sh2000_0000, 32'sh7fff_ffff);
    send_diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_diag(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    send_diag(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    send_diag(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff);
    send_diag(1, 0, -1, 32'sh7fff_ffff);
    send_diag(-ONE, -ONE, 32'sh4000_0001, 0);
    send_matrix('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                  32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                  32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff});
    send_matrix('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
    send_matrix('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
    // Pause until every outstanding word has come back.
    drain();

    sender_idle = 16;
    receiver_idle = 77;
    repeat (330) send_random();
    drain();
    sender_idle = 77;
    receiver_idle = 16;
    repeat (330) send_random();
    sender_idle = 0;
    receiver_idle = 0;
    repeat (340) send_random();

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d quaternion words: trace %0d, y %0d, z %0d, x %0d.",
             sb.n_checked, sb.branch_seen[0], sb.branch_seen[1],
             sb.branch_seen[2], sb.branch_seen[3]);
    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// File: rotation_matrix_to_quaternion_top.f
+incdir+hdl
hdl/rmq_pkg.sv
hdl/rmq_prep.sv
hdl/rmq_sqrt.sv
hdl/rmq_div.sv
hdl/rotation_matrix_to_quaternion_top.sv
hdl/rmq_checker.sv
tb/testbench.sv
